### hdl/circle_rasterizer_assert.svh
// ---------------------------------------------------------------------------
// circle_rasterizer assertion macros
// Clocked property checks on clock, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_ASSERT_SVH
`define CIRCLE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// check outside of reset
`define CRAS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds around reset
`define CRAS_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define CRAS_ASSERT(name, prop, msg)
`define CRAS_ASSERT_RST(name, prop, msg)

`endif

`endif

### hdl/cras_pkg.sv
// ---------------------------------------------------------------------------
// cras_pkg
// Widths, constants and shared types of the midpoint circle rasterizer.
// ---------------------------------------------------------------------------
package cras_pkg;

   localparam int COORD_BITS = 10;
   localparam int OFSY_BITS  = COORD_BITS + 1;
   localparam int OFSX_BITS  = COORD_BITS + 2;
   localparam int DEC_BITS   = COORD_BITS + 4;
   localparam int PIX_BITS   = COORD_BITS + 2;
   localparam int COLOR_BITS = 4;
   localparam int OCT_BITS   = 3;
   localparam int N_OCT      = 1 << OCT_BITS;

   localparam logic [OCT_BITS-1:0] LAST_OCTANT = OCT_BITS'(N_OCT - 1);

   localparam logic signed [DEC_BITS-1:0] DEC_INIT  = DEC_BITS'(3);
   localparam logic signed [DEC_BITS-1:0] STEP_FLAT = DEC_BITS'(6);
   localparam logic signed [DEC_BITS-1:0] STEP_DIAG = DEC_BITS'(10);

   localparam logic [COLOR_BITS-1:0] OCT_COLOR [N_OCT] = '{
      COLOR_BITS'(4),  COLOR_BITS'(14), COLOR_BITS'(2),  COLOR_BITS'(14),
      COLOR_BITS'(12), COLOR_BITS'(14), COLOR_BITS'(15), COLOR_BITS'(6)
   };

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   // one set of eight symmetric points, handed from front to back
   typedef struct packed {
      logic [COORD_BITS-1:0]       cx;
      logic [COORD_BITS-1:0]       cy;
      logic signed [OFSX_BITS-1:0] ofs_x;
      logic signed [OFSY_BITS-1:0] ofs_y;
      logic                        done;
   } point_set_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hdl/cras_intf.sv
// ---------------------------------------------------------------------------
// cras_intf
// Valid/ready channels of the circle rasterizer: command in, pixels out.
// ---------------------------------------------------------------------------
interface cras_req_if import cras_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [COORD_BITS-1:0] radius;

   modport source (output valid, kind, center_x, center_y, radius, input ready);
   modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface cras_rsp_if import cras_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [PIX_BITS-1:0]  pixel_x;
   logic signed [PIX_BITS-1:0]  pixel_y;
   logic [COLOR_BITS-1:0]       color;
   logic [OCT_BITS-1:0]         octant;
   logic                        last;
   logic                        done_res;

   modport source (output valid, pixel_x, pixel_y, color, octant, last, done_res,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, color, octant, last, done_res,
                   output ready);
endinterface

### hdl/cras_front.sv
// ---------------------------------------------------------------------------
// cras_front
// Takes commands, runs the midpoint decision update and queues point sets.
// ---------------------------------------------------------------------------
module cras_front import cras_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cras_req_if.sink         req_ch,
   input  queue_status_type q_status,
   output logic             push,
   output point_set_type    push_data
);

   `include "circle_rasterizer_assert.svh"

   logic                        active_ff, active_in;
   logic signed [OFSX_BITS-1:0] offx_ff, offx_in;
   logic signed [OFSY_BITS-1:0] offy_ff, offy_in;
   logic signed [DEC_BITS-1:0]  dec_ff, dec_in;
   logic [COORD_BITS-1:0]       cx_ff, cx_in;
   logic [COORD_BITS-1:0]       cy_ff, cy_in;

   logic                        accept;
   logic                        is_start;
   logic                        done;
   logic signed [DEC_BITS-1:0]  x4;
   logic signed [DEC_BITS-1:0]  y4;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_start     = (req_ch.kind == KIND_START);

   // a step on an idle circle is taken and dropped
   assign push = accept && (is_start || active_ff);

   assign x4 = DEC_BITS'(offx_ff) <<< 2;
   assign y4 = DEC_BITS'(offy_ff) <<< 2;

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      offx_in   = offx_ff;
      offy_in   = offy_ff;
      dec_in    = dec_ff;
      done      = 1'b0;
      active_in = active_ff;
      if (is_start) begin
         cx_in     = req_ch.center_x;
         cy_in     = req_ch.center_y;
         offx_in   = '0;
         offy_in   = OFSY_BITS'(req_ch.radius);
         dec_in    = DEC_INIT - (DEC_BITS'(req_ch.radius) <<< 1);
         active_in = 1'b1;
      end else begin
         if (dec_ff > 0) begin
            dec_in  = dec_ff + x4 - y4 + STEP_DIAG;
            offy_in = offy_ff - OFSY_BITS'(1);
         end else begin
            dec_in  = dec_ff + x4 + STEP_FLAT;
         end
         offx_in   = offx_ff + OFSX_BITS'(1);
         done      = offx_in > OFSX_BITS'(offy_in);
         active_in = !done;
      end
   end

   assign push_data.cx    = cx_in;
   assign push_data.cy    = cy_in;
   assign push_data.ofs_x = offx_in;
   assign push_data.ofs_y = offy_in;
   assign push_data.done  = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         offx_ff   <= '0;
         offy_ff   <= '0;
         dec_ff    <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else if (push) begin
         active_ff <= active_in;
         offx_ff   <= offx_in;
         offy_ff   <= offy_in;
         dec_ff    <= dec_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
      end
   end

   `CRAS_ASSERT(a_end_on_done, $fell(active_ff) && !$past(reset) |-> $past(push && push_data.done), "circle ended without a finishing point set")

endmodule

### hdl/cras_queue.sv
// ---------------------------------------------------------------------------
// cras_queue
// Two-entry queue of point sets between the front and the back.
// ---------------------------------------------------------------------------
module cras_queue import cras_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  point_set_type    push_data,
   input  logic             pop,
   output point_set_type    head,
   output queue_status_type status
);

   `include "circle_rasterizer_assert.svh"

   point_set_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CRAS_ASSERT(a_no_overflow, push |-> !status.full, "push into a full queue")
   `CRAS_ASSERT(a_no_underflow, pop |-> !status.empty, "pop from an empty queue")

endmodule

### hdl/cras_back.sv
// ---------------------------------------------------------------------------
// cras_back
// Walks each queued set's eight octants, one pixel per cycle unless stalled.
// ---------------------------------------------------------------------------
module cras_back import cras_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  point_set_type    head,
   input  queue_status_type q_status,
   output logic             pop,
   cras_rsp_if.source       rsp_ch
);

   `include "circle_rasterizer_assert.svh"

   logic [OCT_BITS-1:0]        oct_ff, oct_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0]        px_ff, px_in;
   logic [PIX_BITS-1:0]        py_ff, py_in;
   logic [COLOR_BITS-1:0]      color_ff;
   logic [OCT_BITS-1:0]        octant_ff;
   logic                       last_ff;
   logic                       done_ff;

   logic                       load;
   logic [PIX_BITS-1:0]        ex;
   logic [PIX_BITS-1:0]        ey;
   logic [PIX_BITS-1:0]        dx;
   logic [PIX_BITS-1:0]        dy;

   assign load = !q_status.empty && (!rsp_valid_ff || rsp_ch.ready);
   assign pop  = load && (oct_ff == LAST_OCTANT);

   assign ex = PIX_BITS'(head.ofs_x);
   assign ey = PIX_BITS'(head.ofs_y);

   // octant order: (x,y) (x,-y) (-x,-y) (-x,y) (y,x) (y,-x) (-y,-x) (-y,x)
   always_comb begin
      case (oct_ff)
         3'd0:    begin dx = ex;  dy = ey;  end
         3'd1:    begin dx = ex;  dy = -ey; end
         3'd2:    begin dx = -ex; dy = -ey; end
         3'd3:    begin dx = -ex; dy = ey;  end
         3'd4:    begin dx = ey;  dy = ex;  end
         3'd5:    begin dx = ey;  dy = -ex; end
         3'd6:    begin dx = -ey; dy = -ex; end
         default: begin dx = -ey; dy = ex;  end
      endcase
      px_in = PIX_BITS'(head.cx) + dx;
      py_in = PIX_BITS'(head.cy) + dy;
   end

   always_comb begin
      oct_in       = load ? oct_ff + OCT_BITS'(1) : oct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oct_ff       <= oct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         color_ff  <= OCT_COLOR[oct_ff];
         octant_ff <= oct_ff;
         last_ff   <= (oct_ff == LAST_OCTANT);
         done_ff   <= head.done;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.pixel_x  = px_ff;
   assign rsp_ch.pixel_y  = py_ff;
   assign rsp_ch.color    = color_ff;
   assign rsp_ch.octant   = octant_ff;
   assign rsp_ch.last     = last_ff;
   assign rsp_ch.done_res = done_ff;

   `CRAS_ASSERT_RST(a_idle_after_reset, $past(reset) |-> !rsp_valid_ff, "pixel shown right after reset")
   `CRAS_ASSERT(a_set_held, rsp_valid_ff && !last_ff && rsp_ch.ready |-> !q_status.empty, "point set left the queue before its eighth pixel")

endmodule

### hdl/circle_rasterizer.sv
// ---------------------------------------------------------------------------
// circle_rasterizer
// Midpoint circle engine: start/step commands in, eight mirrored pixels out.
// ---------------------------------------------------------------------------
//  channel  dir  per transaction
//  req_ch   in   kind, center_x, center_y, radius
//  rsp_ch   out  pixel_x, pixel_y, color, octant, last, done_res
//
//  A start or an active step yields eight pixels, one per cycle from the back
//  end while rsp_ch is not stalled. With the back end idle, a command passes
//  through the point-set queue and the output register before its first
//  pixel is valid.
//  A two-entry point-set queue lets the front take commands while pixels drain;
//  req_ch.ready drops only when the queue is full. Steps on an idle circle
//  are taken with no pixels. Synchronous reset clears all control.
// ---------------------------------------------------------------------------
module circle_rasterizer import cras_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cras_req_if.sink   req_ch,
   cras_rsp_if.source rsp_ch
);

   logic             push;
   logic             pop;
   point_set_type    push_data;
   point_set_type    head;
   queue_status_type q_status;

   cras_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   cras_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   cras_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
